>>> design/lru_key_value_cache_top_defines.svh
// Assertion macros shared by the checker of the key/value cache.
// Depends on nothing; each macro expects aclk and aresetn in the scope where it is used.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKVC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lkvc_pkg.sv
// Shared constants and types for the LRU key/value cache.
// Used by the top level and its checker; depends on nothing.
package lkvc_pkg;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam int CAP_W = 4;
    typedef logic [CAP_W-1:0] cap_t;
    localparam cap_t CAP_RESET = 4'd8;

    localparam int S_TUSER_W = 1;
    localparam int M_TUSER_W = 2;
    localparam int HIT_BIT   = 0;
    localparam int EVICT_BIT = 1;

endpackage

>>> design/lkvc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the value store of the cache.
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/lru_key_value_cache_top.sv
// Top level of the fully associative key/value cache with LRU replacement.
// Depends on lkvc_pkg and lkvc_ram.

// The cache takes one get or put beat per clock unless m_tready stalls the result, and
// returns exactly one result beat for each, in order. A beat is registered on entry and
// its result is registered in the output register once the output is free or taken; the
// rate of one access per clock rests on the combinational lookup, in which every stored key
// is compared in parallel, the least recent entry is found by its rank and all ranks are
// updated together. Values live in a small RAM read at the hit slot. The capacity register
// may only be written while the cache is idle; no clearing pass follows reset.
module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int ENTRIES     = 8,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // key, write_value
    input  logic [((KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    // opcode
    input  logic [S_TUSER_W-1:0]                      s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // read_value, evicted_key
    output logic [((KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
    // hit, evicted_valid
    output logic [M_TUSER_W-1:0]                      m_tuser,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [CAP_W-1:0]                          cfg_data
);

    localparam int TDATA_W = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W + 1 : CAP_W + 1;

    cap_t                   cap_reg;
    logic                   a_valid_reg;
    logic                   a_op_reg;
    logic [KEY_WIDTH-1:0]   a_key_reg;
    logic [VALUE_WIDTH-1:0] a_val_reg;

    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [KEY_WIDTH-1:0]   key_reg  [ENTRIES];
    logic [IDX_W-1:0]       rec_reg  [ENTRIES];
    logic [IDX_W-1:0]       rec_next [ENTRIES];
    logic [OCC_W-1:0]       occ_reg, occ_next;

    logic                   out_valid_reg;
    logic                   hit_out_reg;
    logic                   rd_sel_reg;
    logic                   evv_out_reg;
    logic [KEY_WIDTH-1:0]   evk_out_reg;

    logic                   fire;
    logic                   is_put;
    logic [ENTRIES-1:0]     match_vec, victim_vec, kept_vec;
    logic                   hit;
    logic [IDX_W-1:0]       hit_idx, hit_rank, occ_m1, free_idx;
    logic                   free_found;
    logic [KEY_WIDTH-1:0]   ev_key;
    logic [CMP_W-1:0]       cap_ext, eff_cap;
    logic                   do_evict, do_fill;
    logic [VALUE_WIDTH-1:0] ram_q;

    assign cfg_ready = 1'b1;
    assign fire      = a_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !a_valid_reg || fire;
    assign is_put    = (a_op_reg == OP_PUT);

    assign cap_ext = CMP_W'(cap_reg);
    always_comb begin
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign occ_m1 = IDX_W'(occ_reg - OCC_W'(1));

    always_comb begin
        hit_idx  = '0;
        hit_rank = '0;
        ev_key   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i]  = valid_reg[i] && (key_reg[i] == a_key_reg);
            victim_vec[i] = valid_reg[i] && (rec_reg[i] == occ_m1);
            if (match_vec[i]) begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | rec_reg[i];
            end
            if (victim_vec[i]) begin
                ev_key = ev_key | key_reg[i];
            end
        end
    end

    assign hit      = |match_vec;
    assign do_evict = is_put && !hit && (occ_reg != '0) && (CMP_W'(occ_reg) >= eff_cap);
    assign kept_vec = valid_reg & ~(do_evict ? victim_vec : '0);

    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!kept_vec[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign free_found = ~&kept_vec;
    assign do_fill    = is_put && !hit && free_found;

    always_comb begin
        valid_next = kept_vec;
        occ_next   = occ_reg - OCC_W'(do_evict) + OCC_W'(do_fill);
        for (int i = 0; i < ENTRIES; i++) begin
            rec_next[i] = rec_reg[i];
            if (hit) begin
                if (match_vec[i]) begin
                    rec_next[i] = '0;
                end else if (valid_reg[i] && (rec_reg[i] < hit_rank)) begin
                    rec_next[i] = rec_reg[i] + IDX_W'(1);
                end
            end else if (do_fill) begin
                if (free_idx == IDX_W'(i)) begin
                    valid_next[i] = 1'b1;
                    rec_next[i]   = '0;
                end else if (kept_vec[i]) begin
                    rec_next[i] = rec_reg[i] + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            occ_reg       <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rec_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                a_valid_reg <= 1'b1;
            end else if (fire) begin
                a_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (fire) begin
                valid_reg <= valid_next;
                occ_reg   <= occ_next;
                for (int i = 0; i < ENTRIES; i++) begin
                    rec_reg[i] <= rec_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_op_reg  <= s_tuser[0];
            a_key_reg <= s_tdata[KEY_WIDTH-1:0];
            a_val_reg <= s_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH];
        end
        if (fire) begin
            hit_out_reg <= hit;
            rd_sel_reg  <= hit && !is_put;
            evv_out_reg <= do_evict;
            evk_out_reg <= do_evict ? ev_key : '0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (do_fill && (free_idx == IDX_W'(i))) begin
                    key_reg[i] <= a_key_reg;
                end
            end
        end
    end

    lkvc_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .clk   (aclk),
        .we    (fire && is_put && (hit || free_found)),
        .waddr (hit ? hit_idx : free_idx),
        .wdata (a_val_reg),
        .re    (fire),
        .raddr (hit_idx),
        .rdata (ram_q)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({evk_out_reg, (rd_sel_reg ? ram_q : {VALUE_WIDTH{1'b0}})});
    assign m_tuser  = {evv_out_reg, hit_out_reg};

endmodule

>>> design/lkvc_checker.sv
// Port-level assertions for the key/value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_top_defines.svh.
`include "lru_key_value_cache_top_defines.svh"

module lkvc_checker
    import lkvc_pkg::*;
#(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input logic                                      aclk,
    input logic                                      aresetn,
    input logic                                      s_tvalid,
    input logic                                      s_tready,
    input logic [((KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    input logic [S_TUSER_W-1:0]                      s_tuser,
    input logic                                      m_tvalid,
    input logic                                      m_tready,
    input logic [((KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
    input logic [M_TUSER_W-1:0]                      m_tuser,
    input logic                                      cfg_valid,
    input logic                                      cfg_ready,
    input logic [CAP_W-1:0]                          cfg_data
);

    logic [VALUE_WIDTH-1:0] rd_value;
    logic [KEY_WIDTH-1:0]   ev_key;

    assign rd_value = m_tdata[VALUE_WIDTH-1:0];
    assign ev_key   = m_tdata[KEY_WIDTH+VALUE_WIDTH-1:VALUE_WIDTH];

    `LKVC_ASSERT_SAME(a_value_needs_hit, m_tvalid && (rd_value != '0), m_tuser[HIT_BIT], "read value on a miss")
    `LKVC_ASSERT_SAME(a_evict_on_miss, m_tvalid && m_tuser[EVICT_BIT], !m_tuser[HIT_BIT], "eviction on a hit")
    `LKVC_ASSERT_SAME(a_key_needs_evict, m_tvalid && (ev_key != '0), m_tuser[EVICT_BIT], "evicted key without eviction")
    `LKVC_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")

endmodule

bind lru_key_value_cache_top lkvc_checker #(
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_lkvc_checker (.*);

>>> dv/tb.sv
// Self-checking testbench for the LRU key/value cache: directed and random get/put beats
// against an in-bench model of the entry store, recency ranks and capacity register.
// Depends on lkvc_pkg and lru_key_value_cache_top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lkvc_pkg::*;

    localparam int ENTRIES = 8;
    localparam int WORD_W = 32;
    localparam int BUS_W = ((2 * WORD_W + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 90;
    localparam int QUIET_TAIL = 100;
    localparam int POOL_SIZE = 12;

    typedef enum logic [1:0] {STEP_ACCESS, STEP_CAPACITY, STEP_DRAIN} step_kind_t;

    typedef struct {
        step_kind_t        kind;
        logic              op;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] wval;
        cap_t              cap;
    } cache_step_t;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] read_value;
        logic              evicted;
        logic [WORD_W-1:0] evicted_key;
    } lookup_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BUS_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BUS_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cap_t              cfg_data = '0;

    lru_key_value_cache_top dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_data
    );

    // Model of the entry store.
    logic              slot_used [ENTRIES] = '{default: 1'b0};
    logic [WORD_W-1:0] slot_key  [ENTRIES];
    logic [WORD_W-1:0] slot_data [ENTRIES];
    logic [2:0]        slot_rank [ENTRIES] = '{default: 3'd0};
    logic [3:0]        fill_level = '0;
    cap_t              capacity_reg = CAP_RESET;

    cache_step_t    pending_steps[$];
    lookup_result_t expected_results[$];
    cache_step_t    cur_step;

    int   sent_total = 0;
    int   seen_total = 0;
    int   mismatches = 0;
    int   src_gap = 0;
    int   sink_gap = 0;
    int   settle = 0;
    int   hold_left = 0;
    int   hold_trips = 0;
    logic src_idle_on = 1'b1;
    logic sink_idle_on = 1'b1;
    logic quiet = 1'b0;

    function automatic lookup_result_t cache_access(logic op, logic [WORD_W-1:0] key,
                                                    logic [WORD_W-1:0] wval);
        lookup_result_t r;
        int found;
        int victim;
        int freeslot;
        int lim;
        logic [2:0] old_rank;
        r = '0;
        found = -1;
        victim = -1;
        freeslot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && slot_used[i] && slot_key[i] == key) found = i;
        if (found >= 0) begin
            r.hit = 1'b1;
            if (op == OP_PUT) slot_data[found] = wval;
            else r.read_value = slot_data[found];
            old_rank = slot_rank[found];
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i] && i != found && slot_rank[i] < old_rank)
                    slot_rank[i] = slot_rank[i] + 3'd1;
            slot_rank[found] = '0;
        end else if (op == OP_PUT) begin
            lim = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
            if (fill_level >= lim && fill_level > 0) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                        victim = i;
                if (victim >= 0) begin
                    slot_used[victim] = 1'b0;
                    fill_level = fill_level - 4'd1;
                    r.evicted = 1'b1;
                    r.evicted_key = slot_key[victim];
                end
            end
            for (int i = 0; i < ENTRIES; i++)
                if (freeslot < 0 && !slot_used[i]) freeslot = i;
            if (freeslot >= 0) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_used[i]) slot_rank[i] = slot_rank[i] + 3'd1;
                slot_used[freeslot] = 1'b1;
                slot_key[freeslot] = key;
                slot_data[freeslot] = wval;
                slot_rank[freeslot] = '0;
                fill_level = fill_level + 4'd1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        if (mismatches < 200)
            $display("mismatch at %0t ns: %s got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic add_access(logic op, logic [WORD_W-1:0] key, logic [WORD_W-1:0] wval);
        cache_step_t st;
        st.kind = STEP_ACCESS;
        st.op = op;
        st.key = key;
        st.wval = wval;
        st.cap = '0;
        pending_steps.push_back(st);
    endtask

    task automatic add_capacity(cap_t cap);
        cache_step_t st;
        st.kind = STEP_CAPACITY;
        st.op = OP_GET;
        st.key = '0;
        st.wval = '0;
        st.cap = cap;
        pending_steps.push_back(st);
    endtask

    task automatic add_drain();
        cache_step_t st;
        st.kind = STEP_DRAIN;
        st.op = OP_GET;
        st.key = '0;
        st.wval = '0;
        st.cap = '0;
        pending_steps.push_back(st);
    endtask

    initial begin : clock_gen
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin : feed
        cache_step_t nxt;
        logic offer;
        logic cfg_go;
        logic took;
        int outstanding;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            took = s_tvalid && s_tready;
            offer = s_tvalid && !s_tready;
            cfg_go = cfg_valid && !cfg_ready;
            if (took) begin
                expected_results.push_back(cache_access(cur_step.op, cur_step.key,
                                                        cur_step.wval));
                sent_total <= sent_total + 1;
            end
            if (cfg_valid && cfg_ready) begin
                capacity_reg = cfg_data;
                void'(pending_steps.pop_front());
                settle = 0;
                src_idle_on = $urandom_range(0, 3) != 0;
            end
            outstanding = sent_total + int'(took) - seen_total;
            if (!offer && !cfg_go) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_steps.size() != 0) begin
                    nxt = pending_steps[0];
                    case (nxt.kind)
                        STEP_ACCESS: begin
                            if (src_idle_on && !quiet && $urandom_range(0, 5) == 0) begin
                                src_gap = $urandom_range(0, 12);
                            end else begin
                                cur_step = nxt;
                                void'(pending_steps.pop_front());
                                offer = 1'b1;
                                s_tdata <= {nxt.wval, nxt.key};
                                s_tuser <= nxt.op;
                            end
                        end
                        STEP_DRAIN: begin
                            if (outstanding == 0) begin
                                void'(pending_steps.pop_front());
                                src_idle_on = $urandom_range(0, 3) != 0;
                            end
                        end
                        default: begin
                            if (outstanding == 0) begin
                                if (settle < SETTLE_CYCLES) begin
                                    settle++;
                                end else begin
                                    cfg_go = 1'b1;
                                    cfg_data <= nxt.cap;
                                end
                            end
                        end
                    endcase
                end
            end
            s_tvalid <= offer;
            cfg_valid <= cfg_go;
            quiet <= pending_steps.size() < QUIET_TAIL;
        end
    end

    always @(posedge aclk) begin : receiver_hold
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_trips < 2 && seen_total >= 150 + 300 * hold_trips) begin
            hold_left <= HOLD_CYCLES;
            hold_trips <= hold_trips + 1;
        end
    end

    always @(posedge aclk) begin : watch
        lookup_result_t want;
        logic rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected, read_value",
                                    m_tdata[WORD_W-1:0], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser[HIT_BIT] !== want.hit)
                        report_mismatch("hit", m_tuser[HIT_BIT], want.hit);
                    if (m_tdata[WORD_W-1:0] !== want.read_value)
                        report_mismatch("read_value", m_tdata[WORD_W-1:0], want.read_value);
                    if (m_tuser[EVICT_BIT] !== want.evicted)
                        report_mismatch("evicted_valid", m_tuser[EVICT_BIT], want.evicted);
                    if (m_tdata[2*WORD_W-1:WORD_W] !== want.evicted_key)
                        report_mismatch("evicted_key", m_tdata[2*WORD_W-1:WORD_W],
                                        want.evicted_key);
                end
                if (seen_total % 50 == 49) sink_idle_on = $urandom_range(0, 3) != 0;
                seen_total <= seen_total + 1;
            end
            if (hold_left != 0) begin
                rdy = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                rdy = 1'b0;
            end else if (sink_idle_on && !quiet && $urandom_range(0, 4) == 0) begin
                sink_gap = $urandom_range(0, 12);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    initial begin : stimulus
        logic [WORD_W-1:0] key_pool [POOL_SIZE];
        cap_t phase_caps [9];
        logic [WORD_W-1:0] k;
        logic [WORD_W-1:0] v;
        int pick;

        // Capacity zero behaves as one: every new key pushes out the previous one.
        add_capacity(4'd0);
        add_access(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        add_access(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        add_access(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
        add_access(OP_GET, 32'hFFFF_FFFF, 32'h1234_5678);
        add_access(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        add_access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        add_capacity(4'd3);
        add_access(OP_PUT, 32'h0000_0001, 32'hA5A5_A5A5);
        add_access(OP_PUT, 32'h0000_0002, 32'h5A5A_5A5A);
        add_access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        add_access(OP_PUT, 32'h0000_0003, 32'h0000_0001);
        // Capacity above the number of entries is clipped to the full store.
        add_capacity(4'd15);
        for (int i = 4; i <= 9; i++) add_access(OP_PUT, i, ~i);
        add_access(OP_GET, 32'h0000_0002, 32'h0000_0000);

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();
        phase_caps = '{4'd8, 4'd1, 4'd5, 4'd2, 4'd15, 4'd0, 4'd7, 4'd3, 4'd8};
        foreach (phase_caps[p]) begin
            add_capacity(phase_caps[p]);
            for (int n = 0; n < 89; n++) begin
                k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                 : $urandom();
                pick = $urandom_range(0, 15);
                v = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom();
                add_access($urandom_range(0, 1) ? OP_PUT : OP_GET, k, v);
                if ((p == 3 && n == 40) || $urandom_range(0, 59) == 0) add_drain();
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        do @(negedge aclk);
        while (pending_steps.size() != 0 || s_tvalid || cfg_valid || seen_total < sent_total);
        repeat (8) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch("results never returned, count", expected_results.size(), 0);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(4_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
